// File: rtl/core/reliable_message_retransmit_table_top_macros.svh
// assertion macros for the retransmit table
// no dependencies; included by rmrt_engine, the module that carries checks
`ifndef RELIABLE_MESSAGE_RETRANSMIT_TABLE_TOP_MACROS_SVH
`define RELIABLE_MESSAGE_RETRANSMIT_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RMRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmrt check failed");
`define RMRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmrt check failed");
`else
`define RMRT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RMRT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/rmrt_pkg.sv
// shared types and codes of the retransmit table
// no dependencies
package rmrt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_IGNORED = 3'd2;
  localparam logic [2:0] KIND_ACKED   = 3'd3;
  localparam logic [2:0] KIND_SEND    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET_FLAG_MASK = 2'd2;

  typedef struct packed {
    logic [7:0] resend_interval;
    logic [7:0] send_limit;
    logic [7:0] forget_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] rcp;
    logic [7:0]  flags;
    logic [15:0] pref;
    logic [10:0] plen;
    logic [7:0]  cooldown;
    logic [7:0]  age;
    logic        mark_new;
    logic        mark_del;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [15:0] rcp;
    logic [7:0]  flags;
    logic [15:0] pref;
    logic [10:0] plen;
    logic        resend;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ONE,
    ST_ADD,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_ACK_DONE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_FLUSH,
    ST_RET_RD,
    ST_RET_CHK
  } state_t;

endpackage

// File: rtl/core/rmrt_if.sv
// valid/ready channel interfaces for requests and results
// no dependencies
interface rmrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] recipients;
  logic [7:0]  add_flags;
  logic [15:0] payload_ref;
  logic [10:0] payload_len;
  logic [31:0] ack_seq;
  logic [15:0] acker_mask;

  modport source (
    output valid, func, recipients, add_flags, payload_ref, payload_len, ack_seq, acker_mask,
    input  ready
  );
  modport sink (
    input  valid, func, recipients, add_flags, payload_ref, payload_len, ack_seq, acker_mask,
    output ready
  );
endinterface

interface rmrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [31:0] out_seq;
  logic [15:0] out_recipients;
  logic [7:0]  out_flags;
  logic [15:0] out_payload_ref;
  logic [10:0] out_payload_len;
  logic        out_resend;
  logic        out_last;

  modport source (
    output valid, out_kind, out_seq, out_recipients, out_flags, out_payload_ref,
           out_payload_len, out_resend, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_seq, out_recipients, out_flags, out_payload_ref,
           out_payload_len, out_resend, out_last,
    output ready
  );
endinterface

// File: rtl/core/rmrt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module rmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/rmrt_out_stage.sv
// output register of the result channel
// depends on rmrt_pkg and rmrt_out_if
module rmrt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rmrt_pkg::result_t res,
  output logic             free,
  rmrt_out_if.source       rsp
);
  import rmrt_pkg::*;

  logic    valid;
  result_t data;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= res;
    end
  end

  assign rsp.valid           = valid;
  assign rsp.out_kind        = data.kind;
  assign rsp.out_seq         = data.seq;
  assign rsp.out_recipients  = data.rcp;
  assign rsp.out_flags       = data.flags;
  assign rsp.out_payload_ref = data.pref;
  assign rsp.out_payload_len = data.plen;
  assign rsp.out_resend      = data.resend;
  assign rsp.out_last        = data.last;

endmodule

// File: rtl/core/rmrt_engine.sv
// sequencer that reads, modifies and writes back ring entries
// depends on rmrt_pkg, rmrt_in_if and the assertion macros
`include "reliable_message_retransmit_table_top_macros.svh"
module rmrt_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int PEER_COUNT  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rmrt_pkg::cfg_t                   cfg,
  rmrt_in_if.sink                          req,
  output logic                             ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]   ram_waddr,
  output logic [rmrt_pkg::ENTRY_W-1:0]     ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]   ram_raddr,
  input  logic [rmrt_pkg::ENTRY_W-1:0]     ram_rdata,
  output logic                             push,
  output rmrt_pkg::result_t                res,
  input  logic                             out_free
);
  import rmrt_pkg::*;

  localparam int PTR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(TABLE_DEPTH - 1);
  localparam logic [RES_W-1:0] MAX_RES_C = RES_W'(MAX_RESULTS);
  localparam logic [15:0] PEER_MASK =
    (PEER_COUNT >= 16) ? 16'hFFFF : 16'((17'd1 << PEER_COUNT) - 17'd1);

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] h,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(off);
    if (sum >= SUM_W'(TABLE_DEPTH)) begin
      sum = sum - SUM_W'(TABLE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [31:0]       next_seq, next_seq_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [RES_W-1:0]  n, n_next;
  logic              pend_valid, pend_valid_next;
  result_t           pend, pend_next;

  // latched request beat
  logic [2:0]  kind_q;
  logic [15:0] rcp_q;
  logic [7:0]  flags_q;
  logic [15:0] pref_q;
  logic [10:0] plen_q;
  logic [31:0] ack_seq_q;
  logic [15:0] ack_q;

  logic             in_ready;
  logic             accept;
  logic [15:0]      rcp_in;
  logic [2:0]       disp_kind;
  entry_t           rd_e;
  entry_t           wr_e;
  logic [CNT_W-1:0] k_inc;
  logic             k_last;
  logic [PTR_W-1:0] slot_k;
  logic [PTR_W-1:0] slot_k1;
  logic [PTR_W-1:0] slot_cnt;
  logic             ack_hit;
  logic [15:0]      ack_rcp;
  logic             due;
  logic             cool;
  logic             stall;
  logic [RES_W-1:0] n_after;
  logic             walk_more;
  logic [7:0]       age_inc;
  logic             drop;

  assign accept    = req.valid && in_ready;
  assign rcp_in    = req.recipients & PEER_MASK;
  assign disp_kind = (rcp_in == 16'd0) ? KIND_IGNORED : KIND_FULL;

  assign rd_e     = entry_t'(ram_rdata);
  assign k_inc    = k + CNT_W'(1);
  assign k_last   = (k_inc == count);
  assign slot_k   = slot_of(head, k);
  assign slot_k1  = slot_of(head, k_inc);
  assign slot_cnt = slot_of(head, count);

  assign ack_hit  = (rd_e.seq == ack_seq_q);
  assign ack_rcp  = rd_e.rcp & ~ack_q;

  assign due       = !rd_e.mark_del && (rd_e.rcp != 16'd0) && (rd_e.cooldown == 8'd0);
  assign cool      = !rd_e.mark_del && !due && (rd_e.cooldown != 8'd0);
  assign stall     = due && pend_valid && !out_free;
  assign n_after   = n + RES_W'(due);
  assign walk_more = !k_last && (n_after < MAX_RES_C);
  assign age_inc   = (rd_e.age != 8'hFF) ? rd_e.age + 8'd1 : rd_e.age;
  assign drop      = ((rd_e.flags & cfg.forget_flag_mask) != 8'd0) || (age_inc >= cfg.send_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      count      <= '0;
      next_seq   <= '0;
      k          <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      next_seq   <= next_seq_next;
      k          <= k_next;
      n          <= n_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (accept) begin
      kind_q    <= disp_kind;
      rcp_q     <= rcp_in;
      flags_q   <= req.add_flags;
      pref_q    <= req.payload_ref;
      plen_q    <= req.payload_len;
      ack_seq_q <= req.ack_seq;
      ack_q     <= req.acker_mask & PEER_MASK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.func)
            FUNC_ADD: begin
              if (rcp_in == 16'd0 || count >= DEPTH_C) begin
                state_next = ST_ONE;
              end else begin
                state_next = ST_ADD;
              end
            end
            FUNC_ACK:  state_next = ST_ACK_RD;
            FUNC_TICK: state_next = ST_TICK_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ONE, ST_ADD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK_RD: begin
        state_next = (count == '0) ? ST_ACK_DONE : ST_ACK_CHK;
      end
      ST_ACK_CHK: begin
        if (ack_hit || k_last) begin
          state_next = ST_ACK_DONE;
        end
      end
      ST_ACK_DONE: begin
        if (out_free) begin
          state_next = ST_RET_RD;
        end
      end
      ST_TICK_RD: begin
        state_next = (count == '0) ? ST_TICK_FLUSH : ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        if (!stall && !walk_more) begin
          state_next = ST_TICK_FLUSH;
        end
      end
      ST_TICK_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_RET_RD;
        end
      end
      ST_RET_RD: begin
        state_next = (count == '0) ? ST_IDLE : ST_RET_CHK;
      end
      ST_RET_CHK: begin
        state_next = rd_e.mark_del ? ST_RET_RD : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = slot_k;
    wr_e            = rd_e;
    ram_re          = 1'b0;
    ram_raddr       = slot_k;
    push            = 1'b0;
    res             = '0;
    head_next       = head;
    count_next      = count;
    next_seq_next   = next_seq;
    k_next          = k;
    n_next          = n;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        k_next   = '0;
        n_next   = '0;
      end
      ST_ONE: begin
        push     = out_free;
        res.kind = kind_q;
        res.last = 1'b1;
      end
      ST_ADD: begin
        if (out_free) begin
          push          = 1'b1;
          res.kind      = KIND_ADDED;
          res.seq       = next_seq + 32'd1;
          res.last      = 1'b1;
          next_seq_next = next_seq + 32'd1;
          count_next    = count + CNT_W'(1);
          ram_we        = 1'b1;
          ram_waddr     = slot_cnt;
          wr_e.seq      = next_seq + 32'd1;
          wr_e.rcp      = rcp_q;
          wr_e.flags    = flags_q;
          wr_e.pref     = pref_q;
          wr_e.plen     = plen_q;
          wr_e.cooldown = 8'd0;
          wr_e.age      = 8'd0;
          wr_e.mark_new = 1'b1;
          wr_e.mark_del = 1'b0;
        end
      end
      ST_ACK_RD, ST_TICK_RD: begin
        ram_re = (count != '0);
      end
      ST_ACK_CHK: begin
        if (ack_hit) begin
          if (!rd_e.mark_del) begin
            ram_we        = 1'b1;
            wr_e.rcp      = ack_rcp;
            wr_e.mark_del = (ack_rcp == 16'd0);
          end
        end else if (!k_last) begin
          ram_re    = 1'b1;
          ram_raddr = slot_k1;
          k_next    = k_inc;
        end
      end
      ST_ACK_DONE: begin
        push     = out_free;
        res.kind = KIND_ACKED;
        res.seq  = ack_seq_q;
        res.last = 1'b1;
      end
      ST_TICK_CHK: begin
        if (!stall) begin
          if (due) begin
            // earlier send goes out now that another follows it
            push             = pend_valid;
            res              = pend;
            pend_valid_next  = 1'b1;
            pend_next.kind   = KIND_SEND;
            pend_next.seq    = rd_e.seq;
            pend_next.rcp    = rd_e.rcp;
            pend_next.flags  = rd_e.flags;
            pend_next.pref   = rd_e.pref;
            pend_next.plen   = rd_e.plen;
            pend_next.resend = !rd_e.mark_new;
            pend_next.last   = 1'b0;
            n_next           = n_after;
            ram_we           = 1'b1;
            wr_e.mark_new    = 1'b0;
            wr_e.cooldown    = cfg.resend_interval;
            wr_e.age         = age_inc;
            wr_e.mark_del    = drop;
          end else if (cool) begin
            ram_we        = 1'b1;
            wr_e.cooldown = rd_e.cooldown - 8'd1;
          end
          if (walk_more) begin
            ram_re    = 1'b1;
            ram_raddr = slot_k1;
            k_next    = k_inc;
          end
        end
      end
      ST_TICK_FLUSH: begin
        if (pend_valid && out_free) begin
          push            = 1'b1;
          res             = pend;
          res.last        = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      ST_RET_RD: begin
        ram_re    = (count != '0);
        ram_raddr = head;
      end
      ST_RET_CHK: begin
        if (rd_e.mark_del) begin
          head_next  = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready = in_ready;
  assign ram_wdata = wr_e;

  `RMRT_ASSERT_IMP(a_push_room, clk, rst, push, out_free)
  `RMRT_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= DEPTH_C)
  `RMRT_ASSERT_IMP(a_idle_quiet, clk, rst, state == ST_IDLE, !pend_valid && !ram_we)
  `RMRT_ASSERT_IMP(a_send_cap, clk, rst, state == ST_TICK_CHK, n < MAX_RES_C)
  `RMRT_ASSERT_NXT(a_add_grows, clk, rst, state == ST_ADD && out_free, count == $past(count) + CNT_W'(1))

endmodule

// File: rtl/core/reliable_message_retransmit_table_top.sv
// channel    | dir | handshake     | payload
// req        | in  | valid / ready | func, recipients, add_flags, payload_ref, payload_len,
//            |     |               | ack_seq, acker_mask
// rsp        | out | valid / ready | out_kind .. out_last
// cfg        | in  | cfg_we        | cfg_index, cfg_wdata
//
// add, full or ignored give one result; ack walks the ring up to the matching entry;
// tick walks the ring one entry per cycle while the result port does not stall it, through
// the single read port of the entry ram, and stops once MAX_RESULTS sends are out.
// ack and tick then retire deleted head entries.
// reset clears head, count and sequence; entry ram needs no clearing pass.
// a stalled result port holds the walk only when a new result has nowhere to go.
// depends on rmrt_pkg, rmrt_if, rmrt_engine, rmrt_ram, rmrt_out_stage
module reliable_message_retransmit_table_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int PEER_COUNT  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  rmrt_in_if.sink                        req,
  rmrt_out_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [rmrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import rmrt_pkg::*;

  localparam int PTR_W = $clog2(TABLE_DEPTH);

  cfg_t                 cfg_q;
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 push;
  result_t              res;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.resend_interval  <= 8'd8;
      cfg_q.send_limit       <= 8'd16;
      cfg_q.forget_flag_mask <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESEND_INTERVAL:  cfg_q.resend_interval  <= cfg_wdata;
        CFG_SEND_LIMIT:       cfg_q.send_limit       <= cfg_wdata;
        CFG_FORGET_FLAG_MASK: cfg_q.forget_flag_mask <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rmrt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PEER_COUNT  (PEER_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .req       (req),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .res       (res),
    .out_free  (out_free)
  );

  rmrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmrt_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .res  (res),
    .free (out_free),
    .rsp  (rsp)
  );

endmodule
